### rtl/core/mkct_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mkct_pkg
// Shared types and constants for the masked-key compacting table.
// ----------------------------------------------------------------------------
package mkct_pkg;

  localparam int CAPACITY_DEF = 256;
  localparam int ACT_W        = 3;
  localparam int ID_W         = 32;
  localparam int KEY_DROP_W   = 2;
  localparam int KEY_W        = ID_W - KEY_DROP_W;
  localparam int TAG_W        = 32;
  localparam int COUNT_OUT_W  = 9;

  // Action codes of an input transaction.
  localparam logic [ACT_W-1:0] ACT_UPSERT      = 3'd0;
  localparam logic [ACT_W-1:0] ACT_INSERT_KEEP = 3'd1;
  localparam logic [ACT_W-1:0] ACT_DEL_KEY     = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DEL_KEY_NZ  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DEL_TAG     = 3'd4;
  localparam logic [ACT_W-1:0] ACT_QUERY       = 3'd5;

  // Match criterion broadcast to every cell.
  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_KEY,
    MODE_KEY_NZ,
    MODE_TAG
  } match_mode_t;

  typedef struct packed {
    match_mode_t       mode;
    logic [KEY_W-1:0]  key;
    logic [TAG_W-1:0]  tag;
  } cmd_t;

  // Per-cycle control broadcast from the sequencer to the cells.
  typedef struct packed {
    logic capture;   // register this cell's match result
    logic shift;     // delete: cells at or past the first hit take their neighbor
    logic upd_tag;   // overwrite the tag of the first hit
    logic ins;       // append at the slot equal to the entry count
  } cell_ctrl_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [ID_W-1:0]  key_id;
    logic [TAG_W-1:0] tag_value;
  } in_item_t;

  typedef struct packed {
    logic                   status;
    logic                   found;
    logic [COUNT_OUT_W-1:0] entry_count;
  } out_item_t;

endpackage
`default_nettype wire

### rtl/core/mkct_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mkct_cell
// One table slot: holds a key and a tag, matches them against the broadcast
// command and takes its upper neighbor's contents when the table compacts.
// ----------------------------------------------------------------------------
module mkct_cell #(
  parameter int IDX = 0,
  parameter int CW  = 9
) (
  input  wire logic                       clk,
  input  wire mkct_pkg::cell_ctrl_t       ctrl,
  input  wire mkct_pkg::cmd_t             cmd,
  input  wire logic [CW-1:0]              count,
  input  wire logic                       prefix_le,
  input  wire logic                       prefix_lt,
  input  wire logic [mkct_pkg::KEY_W-1:0] nb_key,
  input  wire logic [mkct_pkg::TAG_W-1:0] nb_tag,
  output logic      [mkct_pkg::KEY_W-1:0] key_o,
  output logic      [mkct_pkg::TAG_W-1:0] tag_o,
  output logic                            hit_o
);

  logic [mkct_pkg::KEY_W-1:0] key_r;
  logic [mkct_pkg::TAG_W-1:0] tag_r;
  logic                       hit_r;
  logic                       slot_valid;
  logic                       at_tail;
  logic                       match;

  assign slot_valid = CW'(IDX) < count;
  assign at_tail    = CW'(IDX) == count;

  always_comb begin
    case (cmd.mode)
      mkct_pkg::MODE_KEY:    match = key_r == cmd.key;
      mkct_pkg::MODE_KEY_NZ: match = (key_r == cmd.key) && (tag_r != '0);
      mkct_pkg::MODE_TAG:    match = tag_r == cmd.tag;
      default:               match = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      hit_r <= slot_valid && match;
    end
    if (ctrl.shift && prefix_le) begin
      key_r <= nb_key;
      tag_r <= nb_tag;
    end else if (ctrl.upd_tag && hit_r && !prefix_lt) begin
      tag_r <= cmd.tag;
    end else if (ctrl.ins && at_tail) begin
      key_r <= cmd.key;
      tag_r <= cmd.tag;
    end
  end

  assign key_o = key_r;
  assign tag_o = tag_r;
  assign hit_o = hit_r;

endmodule
`default_nettype wire

### rtl/core/mkct_prefix.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mkct_prefix
// Inclusive prefix OR over the cell hit vector, built as a log-depth tree.
// ----------------------------------------------------------------------------
module mkct_prefix #(
  parameter int N = 256
) (
  input  wire logic [N-1:0] hits,
  output logic      [N-1:0] incl
);

  localparam int LEVELS = (N > 1) ? $clog2(N) : 1;

  logic [N-1:0] lvl [LEVELS+1];

  assign lvl[0] = hits;

  for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
    for (genvar i = 0; i < N; i++) begin : g_bit
      if (i >= (1 << l)) begin : g_or
        assign lvl[l+1][i] = lvl[l][i] | lvl[l][i-(1<<l)];
      end else begin : g_pass
        assign lvl[l+1][i] = lvl[l][i];
      end
    end
  end

  assign incl = lvl[LEVELS];

endmodule
`default_nettype wire

### rtl/core/masked_key_compacting_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// masked_key_compacting_table
// Packed associative table with insert, update, delete-and-compact and query.
// ----------------------------------------------------------------------------
// Each transaction passes through three steps: it is accepted, then every
// cell compares its key and tag against the command and registers a hit, and
// then a prefix OR over the hits picks the first match and the cells
// update, append or shift down by one slot. A new input transaction is taken
// only while the table is idle; a finished result sits in the output register
// and does not hold up the next input. If that register is still stalled when
// the next result is ready, the table waits in its update cycle.
//
// The table is a row of CAPACITY cells, one per slot. Entries always fill slots
// 0 to count-1 in insertion order. Keys are bits 31..2 of key_id; the two low
// bits never take part in a comparison. A delete removes the first matching
// entry: every cell at or past it loads its upper neighbor, so the whole row
// compacts together. An insert of a new key appends at the slot equal
// to the current count and is rejected with status 1 when the table is full.
// Slot contents are not cleared by reset; only slots below the count are ever
// compared, so no clearing pass is needed. entry_count carries the low nine
// bits of the count.
// ----------------------------------------------------------------------------
module masked_key_compacting_table #(
  parameter int CAPACITY = mkct_pkg::CAPACITY_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire mkct_pkg::in_item_t   in_item,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output mkct_pkg::out_item_t       out_item
);

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_APPLY
  } state_t;

  state_t                          state_r, state_nxt;
  logic [mkct_pkg::ACT_W-1:0]      action_r, action_nxt;
  mkct_pkg::cmd_t                  cmd_r, cmd_nxt;
  logic [CW-1:0]                   count_r, count_nxt;
  logic                            out_valid_r, out_valid_nxt;
  mkct_pkg::out_item_t             out_item_r, out_item_nxt;

  mkct_pkg::cell_ctrl_t            ctrl;
  logic [CAPACITY-1:0]             hits;
  logic [CAPACITY-1:0]             incl;
  logic [CAPACITY-1:0]             excl;
  logic [mkct_pkg::KEY_W-1:0]      cell_key [CAPACITY];
  logic [mkct_pkg::TAG_W-1:0]      cell_tag [CAPACITY];

  logic                            in_accept;
  logic                            out_free;
  logic                            apply;
  logic                            any_hit;
  logic                            is_insert;
  logic                            is_delete;
  logic                            is_query;
  logic                            has_room;
  logic [CW+mkct_pkg::COUNT_OUT_W-1:0] count_ext;
  mkct_pkg::match_mode_t           mode_sel;

  // Input is taken only when the table is idle.
  assign in_stall  = state_r != S_IDLE;
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign apply     = (state_r == S_APPLY) && out_free;

  assign is_insert = (action_r == mkct_pkg::ACT_UPSERT) ||
                     (action_r == mkct_pkg::ACT_INSERT_KEEP);
  assign is_delete = (action_r == mkct_pkg::ACT_DEL_KEY) ||
                     (action_r == mkct_pkg::ACT_DEL_KEY_NZ) ||
                     (action_r == mkct_pkg::ACT_DEL_TAG);
  assign is_query  = action_r == mkct_pkg::ACT_QUERY;
  assign has_room  = count_r < CW'(CAPACITY);
  assign any_hit   = incl[CAPACITY-1];

  // Translate the action into the match criterion the cells apply.
  always_comb begin
    case (in_item.action)
      mkct_pkg::ACT_UPSERT,
      mkct_pkg::ACT_INSERT_KEEP,
      mkct_pkg::ACT_DEL_KEY,
      mkct_pkg::ACT_QUERY:      mode_sel = mkct_pkg::MODE_KEY;
      mkct_pkg::ACT_DEL_KEY_NZ: mode_sel = mkct_pkg::MODE_KEY_NZ;
      mkct_pkg::ACT_DEL_TAG:    mode_sel = mkct_pkg::MODE_TAG;
      default:                  mode_sel = mkct_pkg::MODE_NONE;
    endcase
  end

  // Cell controls: capture hits in the match cycle, modify in the apply cycle.
  always_comb begin
    ctrl.capture = state_r == S_MATCH;
    ctrl.shift   = apply && is_delete && any_hit;
    ctrl.upd_tag = apply && (action_r == mkct_pkg::ACT_UPSERT) && any_hit;
    ctrl.ins     = apply && is_insert && !any_hit && has_room;
  end

  // The row of cells; each takes its upper neighbor's contents on a shift.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [mkct_pkg::KEY_W-1:0] nb_key;
    logic [mkct_pkg::TAG_W-1:0] nb_tag;

    if (i == CAPACITY - 1) begin : g_last
      assign nb_key = '0;
      assign nb_tag = '0;
    end else begin : g_mid
      assign nb_key = cell_key[i+1];
      assign nb_tag = cell_tag[i+1];
    end

    if (i == 0) begin : g_first
      assign excl[i] = 1'b0;
    end else begin : g_rest
      assign excl[i] = incl[i-1];
    end

    mkct_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .cmd       (cmd_r),
      .count     (count_r),
      .prefix_le (incl[i]),
      .prefix_lt (excl[i]),
      .nb_key    (nb_key),
      .nb_tag    (nb_tag),
      .key_o     (cell_key[i]),
      .tag_o     (cell_tag[i]),
      .hit_o     (hits[i])
    );
  end

  mkct_prefix #(
    .N (CAPACITY)
  ) u_prefix (
    .hits (hits),
    .incl (incl)
  );

  assign count_ext = {{mkct_pkg::COUNT_OUT_W{1'b0}}, count_nxt};

  always_comb begin
    state_nxt     = state_r;
    action_nxt    = action_r;
    cmd_nxt       = cmd_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          action_nxt = in_item.action;
          cmd_nxt.mode = mode_sel;
          cmd_nxt.key  = in_item.key_id[mkct_pkg::ID_W-1:mkct_pkg::KEY_DROP_W];
          cmd_nxt.tag  = in_item.tag_value;
          state_nxt  = S_MATCH;
        end
      end
      S_MATCH: begin
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        if (out_free) begin
          out_item_nxt.status = 1'b0;
          out_item_nxt.found  = 1'b0;
          if (is_insert) begin
            out_item_nxt.found = any_hit;
            if (!any_hit) begin
              if (has_room) begin
                count_nxt = count_r + CW'(1);
              end else begin
                out_item_nxt.status = 1'b1;
              end
            end
          end else if (is_delete) begin
            out_item_nxt.found = any_hit;
            if (any_hit) begin
              count_nxt = count_r - CW'(1);
            end
          end else if (is_query) begin
            out_item_nxt.found = any_hit;
          end
          out_item_nxt.entry_count = count_ext[mkct_pkg::COUNT_OUT_W-1:0];
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    action_r   <= action_nxt;
    cmd_r      <= cmd_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

### verif/masked_key_compacting_table_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// masked_key_compacting_table_tb
// Self-checking testbench for the masked-key compacting table.
// ----------------------------------------------------------------------------
// A table model in this file keeps the packed entry list as two queues. It
// steps through every input transaction while the stimulus is built, so the
// generator can aim keys and tags at entries that exist. Each transaction
// carries its expected result, which is armed only when the block accepts it.
// The stimulus opens with a directed set that covers the empty-table, masking,
// zero-tag and unused-action cases. A random part follows that fills the table
// to capacity, pushes inserts against the full table, runs mixed traffic,
// drains to empty and then runs random episodes. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module masked_key_compacting_table_tb;

  localparam int CAP          = mkct_pkg::CAPACITY_DEF;
  localparam int N_ITEMS      = 800;
  localparam int IDLE_LIMIT   = 5000;
  localparam int TAIL_CYCLES  = 20;

  // Action codes that the block must treat as no-ops.
  localparam logic [mkct_pkg::ACT_W-1:0] ACT_SPARE_6 = 3'd6;
  localparam logic [mkct_pkg::ACT_W-1:0] ACT_SPARE_7 = 3'd7;

  // Shape of a stretch of random stimulus.
  typedef enum {EP_GROW, EP_SHRINK, EP_MIXED} episode_t;

  // One queued transaction: the payload, the result it must produce, and a
  // flag that makes the driver wait until every earlier result is back.
  typedef struct packed {
    mkct_pkg::in_item_t  item;
    mkct_pkg::out_item_t result;
    logic                hold;
  } txn_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  mkct_pkg::in_item_t  in_item   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  mkct_pkg::out_item_t out_item;

  // Packed table contents, slot 0 first.
  logic [mkct_pkg::KEY_W-1:0] table_keys[$];
  logic [mkct_pkg::TAG_W-1:0] table_tags[$];

  txn_t                txn_q[$];        // transactions not yet offered to the block
  mkct_pkg::out_item_t result_due_q[$]; // results of accepted transactions, oldest first
  txn_t                cur_txn = '0;    // transaction currently on the input port
  logic                in_taken = 1'b0; // the last rising edge accepted cur_txn
  int                  gap_left = 0;
  int                  burst_left = 0;
  int                  stall_left = 0;
  int                  mismatches = 0;

  masked_key_compacting_table #(
    .CAPACITY(CAP)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Table model
  // --------------------------------------------------------------------------

  // Returns the first slot that meets the criterion, or -1 when none does.
  function automatic int first_hit(mkct_pkg::match_mode_t mode,
                                   logic [mkct_pkg::KEY_W-1:0] key,
                                   logic [mkct_pkg::TAG_W-1:0] tag);
    logic hit;
    for (int i = 0; i < table_keys.size(); i++) begin
      case (mode)
        mkct_pkg::MODE_KEY:    hit = (table_keys[i] == key);
        mkct_pkg::MODE_KEY_NZ: hit = (table_keys[i] == key) && (table_tags[i] != '0);
        mkct_pkg::MODE_TAG:    hit = (table_tags[i] == tag);
        default:               hit = 1'b0;
      endcase
      if (hit) return i;
    end
    return -1;
  endfunction

  // Applies one transaction to the table and returns the result it produces.
  function automatic mkct_pkg::out_item_t apply_to_table(mkct_pkg::in_item_t it);
    mkct_pkg::out_item_t        res;
    logic [mkct_pkg::KEY_W-1:0] key;
    mkct_pkg::match_mode_t      mode;
    int                         slot;
    res  = '0;
    key  = it.key_id[mkct_pkg::ID_W-1:mkct_pkg::KEY_DROP_W];
    case (it.action)
      mkct_pkg::ACT_UPSERT, mkct_pkg::ACT_INSERT_KEEP: begin
        slot = first_hit(mkct_pkg::MODE_KEY, key, it.tag_value);
        if (slot >= 0) begin
          // An existing key is never rejected, even when the table is full.
          res.found = 1'b1;
          if (it.action == mkct_pkg::ACT_UPSERT) table_tags[slot] = it.tag_value;
        end else if (table_keys.size() < CAP) begin
          table_keys.push_back(key);
          table_tags.push_back(it.tag_value);
        end else begin
          res.status = 1'b1;
        end
      end
      mkct_pkg::ACT_DEL_KEY, mkct_pkg::ACT_DEL_KEY_NZ, mkct_pkg::ACT_DEL_TAG: begin
        if (it.action == mkct_pkg::ACT_DEL_KEY) mode = mkct_pkg::MODE_KEY;
        else if (it.action == mkct_pkg::ACT_DEL_KEY_NZ) mode = mkct_pkg::MODE_KEY_NZ;
        else mode = mkct_pkg::MODE_TAG;
        slot = first_hit(mode, key, it.tag_value);
        if (slot >= 0) begin
          // Removing from the queue compacts the later entries down a slot.
          res.found = 1'b1;
          table_keys.delete(slot);
          table_tags.delete(slot);
        end
      end
      mkct_pkg::ACT_QUERY:
        res.found = (first_hit(mkct_pkg::MODE_KEY, key, it.tag_value) >= 0);
      default: ;
    endcase
    res.entry_count = mkct_pkg::COUNT_OUT_W'(table_keys.size());
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus construction
  // --------------------------------------------------------------------------

  function automatic mkct_pkg::in_item_t make_item(logic [mkct_pkg::ACT_W-1:0] action,
                                                   logic [mkct_pkg::ID_W-1:0] id,
                                                   logic [mkct_pkg::TAG_W-1:0] tag);
    mkct_pkg::in_item_t it;
    it.action    = action;
    it.key_id    = id;
    it.tag_value = tag;
    return it;
  endfunction

  // The table model is stepped as each transaction is queued; its result
  // becomes an expectation once the block accepts the transaction.
  task automatic queue_txn(mkct_pkg::in_item_t it, logic hold);
    txn_t t;
    t.item   = it;
    t.result = apply_to_table(it);
    t.hold   = hold;
    txn_q.push_back(t);
  endtask

  // Random ids lean toward a small cluster and the top of the range so that
  // unrelated transactions collide now and then.
  function automatic logic [mkct_pkg::ID_W-1:0] random_id();
    int r;
    r = $urandom_range(99);
    if (r < 10) return mkct_pkg::ID_W'($urandom_range(15));
    if (r < 15) return 32'hFFFF_FFFF - mkct_pkg::ID_W'($urandom_range(3));
    return $urandom;
  endfunction

  function automatic logic [mkct_pkg::TAG_W-1:0] random_tag();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 15) return '1;
    return $urandom;
  endfunction

  function automatic mkct_pkg::in_item_t random_item(episode_t ep);
    mkct_pkg::in_item_t it;
    int                 r;
    int                 hit_pct;
    int                 idx;
    logic               is_ins;
    r = $urandom_range(99);
    case (ep)
      EP_GROW: begin
        if (r < 88) it.action = mkct_pkg::ACT_UPSERT;
        else if (r < 94) it.action = mkct_pkg::ACT_QUERY;
        else if (r < 98) it.action = mkct_pkg::ACT_DEL_KEY;
        else it.action = ACT_SPARE_6;
      end
      EP_SHRINK: begin
        if (r < 5) it.action = mkct_pkg::ACT_UPSERT;
        else if (r < 10) it.action = mkct_pkg::ACT_QUERY;
        else if (r < 98) it.action = mkct_pkg::ACT_DEL_KEY;
        else it.action = ACT_SPARE_6;
      end
      default: begin
        if (r < 40) it.action = mkct_pkg::ACT_UPSERT;
        else if (r < 60) it.action = mkct_pkg::ACT_QUERY;
        else if (r < 96) it.action = mkct_pkg::ACT_DEL_KEY;
        else it.action = ACT_SPARE_6;
      end
    endcase
    // Spread the coarse pick over the variants of each kind of action.
    if (it.action == mkct_pkg::ACT_UPSERT && $urandom_range(1) == 1)
      it.action = mkct_pkg::ACT_INSERT_KEEP;
    if (it.action == mkct_pkg::ACT_DEL_KEY) begin
      case ($urandom_range(2))
        0: it.action = mkct_pkg::ACT_DEL_KEY;
        1: it.action = mkct_pkg::ACT_DEL_KEY_NZ;
        default: it.action = mkct_pkg::ACT_DEL_TAG;
      endcase
    end
    if (it.action == ACT_SPARE_6 && $urandom_range(1) == 1) it.action = ACT_SPARE_7;

    // While growing, inserts mostly bring new keys; otherwise aim at entries.
    is_ins  = (it.action == mkct_pkg::ACT_UPSERT) ||
              (it.action == mkct_pkg::ACT_INSERT_KEEP);
    hit_pct = (ep == EP_GROW && is_ins) ? 15 : 75;
    it.key_id    = random_id();
    it.tag_value = random_tag();
    if (table_keys.size() > 0 && $urandom_range(99) < hit_pct) begin
      idx = $urandom_range(table_keys.size() - 1);
      // Random low bits check that they never take part in a comparison.
      it.key_id = {table_keys[idx], mkct_pkg::KEY_DROP_W'($urandom_range(3))};
      if (it.action == mkct_pkg::ACT_DEL_TAG) begin
        idx = $urandom_range(table_keys.size() - 1);
        it.tag_value = table_tags[idx];
      end
    end
    return it;
  endfunction

  // Input gaps: mostly none or short, a few long, and bursts with none at all.
  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 3) burst_left = $urandom_range(20, 60);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: a new transaction is presented at the falling edge once the
  // previous one has been accepted, after its gap has run out.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : drive_input
    txn_t nxt;
    if (rst_n && (!in_valid || in_taken)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (txn_q.size() == 0 ||
                   (txn_q[0].hold && result_due_q.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        nxt = txn_q.pop_front();
        cur_txn  <= nxt;
        in_item  <= nxt.item;
        in_valid <= 1'b1;
        gap_left <= pick_gap();
      end
    end
  end

  // Output stall: short stalls, a few long ones, and long stretches without.
  always @(negedge clk) begin : drive_stall
    int r;
    if (rst_n) begin
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
      end else begin
        r = $urandom_range(99);
        if (out_stall) begin
          out_stall  <= 1'b0;
          stall_left <= (r < 10) ? $urandom_range(50, 200) : $urandom_range(0, 8);
        end else begin
          out_stall  <= 1'b1;
          stall_left <= (r < 8) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: results are checked against the oldest expectation, and each
  // accepted input transaction arms its own expectation.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : monitor
    mkct_pkg::out_item_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (result_due_q.size() == 0) begin
          report_mismatch("result with no transaction outstanding, count",
                          out_item.entry_count, -1);
        end else begin
          want = result_due_q.pop_front();
          if (out_item.status !== want.status)
            report_mismatch("status", out_item.status, want.status);
          if (out_item.found !== want.found)
            report_mismatch("found", out_item.found, want.found);
          if (out_item.entry_count !== want.entry_count)
            report_mismatch("entry_count", out_item.entry_count, want.entry_count);
        end
      end
      if (in_valid && !in_stall) result_due_q.push_back(cur_txn.result);
      in_taken <= in_valid && !in_stall;
    end
  end

  // The watchdog ends a run in which neither channel moves for too long.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("simulation failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of test
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int       n;
    int       len;
    episode_t ep;

    // Empty table: lookups and deletes find nothing.
    queue_txn(make_item(mkct_pkg::ACT_QUERY,      32'h0000_0000, 32'h0000_0000), 1'b0);
    queue_txn(make_item(mkct_pkg::ACT_DEL_KEY,    32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b0);
    queue_txn(make_item(mkct_pkg::ACT_DEL_TAG,    32'h0000_0000, 32'h0000_0000), 1'b0);
    queue_txn(make_item(mkct_pkg::ACT_DEL_KEY_NZ, 32'h0000_0000, 32'h0000_0000), 1'b0);
    // Inserts into the empty table and at the ends of the key range.
    queue_txn(make_item(mkct_pkg::ACT_UPSERT,      32'h0000_0000, 32'h0000_0000), 1'b0);
    queue_txn(make_item(mkct_pkg::ACT_INSERT_KEEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b0);
    // Ids that differ only in the two low bits name the same entry.
    queue_txn(make_item(mkct_pkg::ACT_UPSERT,      32'h0000_0003, 32'h0000_1234), 1'b0);
    queue_txn(make_item(mkct_pkg::ACT_INSERT_KEEP, 32'h0000_0001, 32'hDEAD_BEEF), 1'b0);
    queue_txn(make_item(mkct_pkg::ACT_QUERY,       32'hFFFF_FFFC, 32'h0000_0000), 1'b0);
    queue_txn(make_item(mkct_pkg::ACT_QUERY,       32'h0000_0004, 32'h0000_0000), 1'b0);
    // A zero tag shields an entry from the nonzero-tag delete.
    queue_txn(make_item(mkct_pkg::ACT_UPSERT,      32'h0000_0010, 32'h0000_0000), 1'b0);
    queue_txn(make_item(mkct_pkg::ACT_DEL_KEY_NZ,  32'h0000_0012, 32'h0000_0000), 1'b0);
    queue_txn(make_item(mkct_pkg::ACT_DEL_KEY_NZ,  32'hFFFF_FFFE, 32'h0000_0000), 1'b0);
    // Delete by tag removes slot 0 and compacts the rest.
    queue_txn(make_item(mkct_pkg::ACT_DEL_TAG,     32'h5555_5555, 32'h0000_1234), 1'b0);
    queue_txn(make_item(mkct_pkg::ACT_UPSERT,      32'hAAAA_AAA8, 32'h5555_5555), 1'b0);
    // Unused action codes leave the table alone.
    queue_txn(make_item(ACT_SPARE_6,               32'h0000_0010, 32'hFFFF_FFFF), 1'b0);
    queue_txn(make_item(ACT_SPARE_7,               32'hAAAA_AAA8, 32'h5555_5555), 1'b0);
    queue_txn(make_item(mkct_pkg::ACT_DEL_KEY,     32'h0000_0013, 32'h0000_0000), 1'b0);
    queue_txn(make_item(mkct_pkg::ACT_DEL_TAG,     32'h0000_0000, 32'h0000_0000), 1'b0);
    queue_txn(make_item(mkct_pkg::ACT_QUERY,       32'hAAAA_AAAB, 32'h0000_0000), 1'b0);
    n = txn_q.size();

    // Fill the table, then keep inserting against the full table.
    while (table_keys.size() < CAP) begin
      queue_txn(random_item(EP_GROW), 1'b0);
      n++;
    end
    repeat (15) begin
      queue_txn(random_item(EP_GROW), 1'b0);
      n++;
    end
    // The sender waits here until every outstanding result has come back.
    queue_txn(random_item(EP_MIXED), 1'b1);
    n++;
    repeat (60) begin
      queue_txn(random_item(EP_MIXED), 1'b0);
      n++;
    end
    // Drain to empty, with a few transactions against the empty table.
    while (table_keys.size() > 0) begin
      queue_txn(random_item(EP_SHRINK), 1'b0);
      n++;
    end
    repeat (5) begin
      queue_txn(random_item(EP_SHRINK), 1'b0);
      n++;
    end
    // Random episodes for the rest of the run.
    while (n < N_ITEMS) begin
      case ($urandom_range(2))
        0: ep = EP_GROW;
        1: ep = EP_SHRINK;
        default: ep = EP_MIXED;
      endcase
      len = $urandom_range(20, 60);
      repeat (len) begin
        queue_txn(random_item(ep), 1'b0);
        n++;
      end
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (txn_q.size() != 0 || in_valid || result_due_q.size() != 0)
      @(posedge clk);
    // Keep running past the last result so that a stray extra result is caught.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
`default_nettype wire
